// File: hdl/assert_macros.svh
// Concurrent check helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define AST_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, off while reset is asserted.
`define AST_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: hdl/hdie_pkg.sv
`default_nettype none

package hdie_pkg;

    localparam int MAX_SF     = 12;
    localparam int MIN_SF     = 6;
    localparam int ROW_W      = 8;
    localparam int NIB_W      = 4;
    localparam int SYM_W      = 12;
    localparam int SF_W       = 4;
    localparam int RATE_W     = 3;
    localparam int POS_W      = 3;
    localparam int ROW_IDX_W  = $clog2(MAX_SF);
    localparam int CNT_W      = $clog2(MAX_SF + 1);
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SF   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LRO  = 2'd2;

    localparam logic [RATE_W-1:0] RATE_MIN = 3'd1;
    localparam logic [RATE_W-1:0] RATE_MAX = 3'd4;

    typedef logic [ROW_W-1:0] row_t;

    typedef struct packed {
        logic [SF_W-1:0]   sf;
        logic [RATE_W-1:0] rate;
        logic              lro;
    } cfg_t;

    // One complete interleave block with the shape it is emitted with
    typedef struct packed {
        row_t [MAX_SF-1:0] rows;
        logic [CNT_W-1:0]  nrows;
        logic [SF_W-1:0]   sf;
        logic [POS_W-1:0]  last_pos;
        logic              hdr;
    } blk_t;

    typedef struct packed {
        logic push;
        blk_t blk;
    } q_wr_t;

    typedef struct packed {
        logic avail;
        blk_t blk;
    } q_rd_t;

    function automatic logic [SF_W-1:0] eff_sf(input logic [SF_W-1:0] sf);
        logic [SF_W-1:0] s;
        s = sf;
        if (s < SF_W'(MIN_SF))
            s = SF_W'(MIN_SF);
        if (s > SF_W'(MAX_SF))
            s = SF_W'(MAX_SF);
        return s;
    endfunction

    function automatic logic [RATE_W-1:0] eff_rate(input logic [RATE_W-1:0] rate);
        logic [RATE_W-1:0] r;
        r = rate;
        if (r < RATE_MIN)
            r = RATE_MIN;
        if (r > RATE_MAX)
            r = RATE_MAX;
        return r;
    endfunction

    function automatic row_t hamming(input logic [NIB_W-1:0] nib,
                                     input logic [RATE_W-1:0] rate);
        logic d0, d1, d2, d3;
        row_t full;
        d0 = nib[0];
        d1 = nib[1];
        d2 = nib[2];
        d3 = nib[3];
        full = {d0, d1, d2, d3, d0 ^ d1 ^ d2, d1 ^ d2 ^ d3, d0 ^ d1 ^ d3, d0 ^ d2 ^ d3};
        if (rate <= RATE_MIN)
            return {3'b000, d0, d1, d2, d3, d0 ^ d1 ^ d2 ^ d3};
        return full >> (RATE_MAX - rate);
    endfunction

endpackage

`default_nettype wire

// File: hdl/hdie_intf.sv
`default_nettype none

interface hdie_in_if;
    logic                       valid;
    logic                       ready;
    logic [hdie_pkg::NIB_W-1:0] nibble;
    logic                       in_header_block;
    logic                       flush_block;

    modport source (output valid, nibble, in_header_block, flush_block, input ready);
    modport sink   (input valid, nibble, in_header_block, flush_block, output ready);
endinterface

interface hdie_out_if;
    logic                       valid;
    logic                       ready;
    logic [hdie_pkg::SYM_W-1:0] symbol;
    logic                       last_of_block;
    logic                       from_header_block;

    modport source (output valid, symbol, last_of_block, from_header_block, input ready);
    modport sink   (input valid, symbol, last_of_block, from_header_block, output ready);
endinterface

interface hdie_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [hdie_pkg::CFG_IDX_W-1:0]  index;
    logic [hdie_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/hamming_diag_interleave_encoder.sv
// Channel | Dir | Payload                                       | Handshake
// nib_ch  | in  | nibble, in_header_block, flush_block           | valid/ready
// sym_ch  | out | symbol, last_of_block, from_header_block       | valid/ready
// cfg     | in  | index (0 sf, 1 code rate, 2 low rate opt), data| valid/ready
//
// nib_ch is ready unless both block slots of the queue are full.
// A finished block is loaded into the emitter, which then gives one symbol a
// cycle while sym_ch is ready, 4+rate symbols in all; rows, rate and sf are
// fixed when the block closes. sym_ch stalls hold the emitter only; the
// encoder keeps filling blocks until both queue slots are taken.
// Reset is asynchronous, active low; config writes are always ready.
`default_nettype none
`include "assert_macros.svh"

module hamming_diag_interleave_encoder (
    input  logic       clk,
    input  logic       rst_n,
    hdie_in_if.sink    nib_ch,
    hdie_out_if.source sym_ch,
    hdie_cfg_if.sink   cfg
);
    import hdie_pkg::*;

    logic [SF_W-1:0]   sf_reg;
    logic [RATE_W-1:0] rate_reg;
    logic              lro_reg;

    cfg_t              cfg_cur;
    q_wr_t             q_wr;
    q_rd_t             q_rd;
    logic              q_full;
    logic              q_pop;
    logic              nib_take;

    assign cfg.ready    = 1'b1;
    assign cfg_cur.sf   = sf_reg;
    assign cfg_cur.rate = rate_reg;
    assign cfg_cur.lro  = lro_reg;
    assign nib_take     = nib_ch.valid && nib_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sf_reg   <= SF_W'(7);
            rate_reg <= RATE_MIN;
            lro_reg  <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_SF:   sf_reg   <= cfg.data[SF_W-1:0];
                REG_RATE: rate_reg <= cfg.data[RATE_W-1:0];
                REG_LRO:  lro_reg  <= cfg.data[0];
                default:  ;
            endcase
        end
    end

    hdie_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_cur),
        .nib_ch (nib_ch),
        .q_full (q_full),
        .q_wr   (q_wr)
    );

    hdie_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .q_wr  (q_wr),
        .pop   (q_pop),
        .full  (q_full),
        .q_rd  (q_rd)
    );

    hdie_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_rd   (q_rd),
        .pop    (q_pop),
        .sym_ch (sym_ch)
    );

    `AST_IMP(a_push_has_room, clk, rst_n, q_wr.push, !q_full)
    `AST_IMP(a_pop_has_block, clk, rst_n, q_pop, q_rd.avail)
    `AST_IMP(a_flush_ends_block, clk, rst_n, nib_take && nib_ch.flush_block, q_wr.push)
    `AST_NXT(a_push_lands, clk, rst_n, q_wr.push && !q_pop, q_rd.avail)

endmodule

`default_nettype wire

// File: hdl/hdie_front.sv
`default_nettype none

module hdie_front (
    input  logic            clk,
    input  logic            rst_n,
    input  hdie_pkg::cfg_t  cfg,
    hdie_in_if.sink         nib_ch,
    input  logic            q_full,
    output hdie_pkg::q_wr_t q_wr
);
    import hdie_pkg::*;

    row_t [MAX_SF-1:0] rows_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic              hdr_reg;

    logic              accept;
    logic              blk_hdr;
    logic [SF_W-1:0]   sf_e;
    logic [RATE_W-1:0] rate;
    logic [CNT_W-1:0]  nrows;
    logic [CNT_W-1:0]  fill_inc;
    logic              done;
    row_t [MAX_SF-1:0] rows_upd;
    row_t [MAX_SF-1:0] rows_out;

    assign nib_ch.ready = !q_full;
    assign accept       = nib_ch.valid && nib_ch.ready;

    always_comb
    begin
        // the first nibble of a block decides its kind
        blk_hdr = (fill_reg == '0) ? nib_ch.in_header_block : hdr_reg;
        sf_e    = eff_sf(cfg.sf);
        rate    = blk_hdr ? RATE_MAX : eff_rate(cfg.rate);
        if (blk_hdr || cfg.lro)
            nrows = CNT_W'(sf_e - SF_W'(2));
        else
            nrows = CNT_W'(sf_e);

        rows_upd = rows_reg;
        fill_inc = fill_reg;
        if (fill_reg < CNT_W'(MAX_SF))
        begin
            rows_upd[fill_reg[ROW_IDX_W-1:0]] = hamming(nib_ch.nibble, rate);
            fill_inc = fill_reg + CNT_W'(1);
        end
        done = nib_ch.flush_block || (fill_inc >= nrows);

        // rows past the fill level are padding and go out as zero
        for (int k = 0; k < MAX_SF; k++)
            rows_out[k] = (CNT_W'(k) < fill_inc) ? rows_upd[k] : '0;

        q_wr.push          = accept && done;
        q_wr.blk.rows      = rows_out;
        q_wr.blk.nrows     = nrows;
        q_wr.blk.sf        = sf_e;
        q_wr.blk.last_pos  = POS_W'(rate + RATE_W'(3));
        q_wr.blk.hdr       = blk_hdr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            hdr_reg  <= 1'b0;
        end
        else if (accept)
        begin
            hdr_reg  <= blk_hdr;
            fill_reg <= done ? '0 : fill_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rows_reg <= rows_upd;
    end

endmodule

`default_nettype wire

// File: hdl/hdie_queue.sv
`default_nettype none

module hdie_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  hdie_pkg::q_wr_t q_wr,
    input  logic            pop,
    output logic            full,
    output hdie_pkg::q_rd_t q_rd
);
    import hdie_pkg::*;

    blk_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign full       = (cnt_reg == QCNT_W'(QDEPTH));
    assign q_rd.avail = (cnt_reg != '0);
    assign q_rd.blk   = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (q_wr.push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (q_wr.push && !pop)
                cnt_reg <= cnt_reg + QCNT_W'(1);
            else if (pop && !q_wr.push)
                cnt_reg <= cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_wr.push)
            mem[wr_ptr_reg] <= q_wr.blk;
    end

endmodule

`default_nettype wire

// File: hdl/hdie_back.sv
`default_nettype none

module hdie_back (
    input  logic            clk,
    input  logic            rst_n,
    input  hdie_pkg::q_rd_t q_rd,
    output logic            pop,
    hdie_out_if.source      sym_ch
);
    import hdie_pkg::*;

    logic              busy_reg;
    row_t [MAX_SF-1:0] rot_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  nrows_reg;
    logic [SF_W-1:0]   sf_reg;
    logic              hdr_reg;

    logic              ov_reg;
    logic [SYM_W-1:0]  sym_reg;
    logic              last_reg;
    logic              ohdr_reg;

    logic              advance;
    logic              step;
    row_t [MAX_SF-1:0] rot_ld;
    row_t [MAX_SF-1:0] rot_adv;
    logic [CNT_W-1:0]  ld_idx;
    logic [MAX_SF-1:0] col_left;
    logic [MAX_SF-1:0] col;
    logic [MAX_SF-1:0] bin;
    logic [SYM_W-1:0]  shifted;
    logic [SYM_W-1:0]  sym_mask;
    logic [SYM_W-1:0]  sym;

    assign advance = !ov_reg || sym_ch.ready;
    assign step    = busy_reg && advance;
    assign pop     = !busy_reg && q_rd.avail;

    always_comb
    begin
        // column 0 reads rows R-1 down to 0, MSB first
        for (int k = 0; k < MAX_SF; k++)
        begin
            ld_idx = q_rd.blk.nrows - CNT_W'(1) - CNT_W'(k);
            if (CNT_W'(k) < q_rd.blk.nrows)
                rot_ld[k] = q_rd.blk.rows[ld_idx[ROW_IDX_W-1:0]];
            else
                rot_ld[k] = '0;
        end

        // each later column starts one row further on
        ld_idx     = nrows_reg - CNT_W'(1);
        rot_adv[0] = rot_reg[ld_idx[ROW_IDX_W-1:0]];
        for (int k = 1; k < MAX_SF; k++)
            rot_adv[k] = rot_reg[k-1];

        for (int j = 0; j < MAX_SF; j++)
            col_left[MAX_SF-1-j] = (CNT_W'(j) < nrows_reg) ? rot_reg[j][pos_reg] : 1'b0;
        col = col_left >> (CNT_W'(MAX_SF) - nrows_reg);

        for (int k = 0; k < MAX_SF; k++)
            bin[k] = ^(col >> k);

        shifted  = SYM_W'(bin) << (sf_reg - SF_W'(nrows_reg));
        sym_mask = ~({SYM_W{1'b1}} << sf_reg);
        sym      = (shifted + SYM_W'(1)) & sym_mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
                busy_reg <= 1'b1;
            else if (step && (pos_reg == '0))
                busy_reg <= 1'b0;

            if (sym_ch.valid && sym_ch.ready)
                ov_reg <= 1'b0;
            if (step)
                ov_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rot_reg   <= rot_ld;
            pos_reg   <= q_rd.blk.last_pos;
            nrows_reg <= q_rd.blk.nrows;
            sf_reg    <= q_rd.blk.sf;
            hdr_reg   <= q_rd.blk.hdr;
        end
        else if (step)
        begin
            rot_reg <= rot_adv;
            pos_reg <= pos_reg - POS_W'(1);
        end

        if (step)
        begin
            sym_reg  <= sym;
            last_reg <= (pos_reg == '0);
            ohdr_reg <= hdr_reg;
        end
    end

    assign sym_ch.valid             = ov_reg;
    assign sym_ch.symbol            = sym_reg;
    assign sym_ch.last_of_block     = last_reg;
    assign sym_ch.from_header_block = ohdr_reg;

endmodule

`default_nettype wire

// File: tb/hamming_diag_interleave_encoder_tb.sv
`default_nettype none

module hamming_diag_interleave_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hdie_pkg::*;

    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 25;
    localparam int RANDOM_PHASES  = 8;

    typedef struct {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             hdr;
    } sym_exp_t;

    logic clk;
    logic rst_n;
    logic steady;
    int   mismatches;
    int   quiet_cycles;

    hdie_in_if  nib_if ();
    hdie_out_if sym_if ();
    hdie_cfg_if cfg_if ();

    hamming_diag_interleave_encoder u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .nib_ch (nib_if),
        .sym_ch (sym_if),
        .cfg    (cfg_if)
    );

    // Shadow of the encoder: settings as written, and the block being filled
    logic [SF_W-1:0]   sf_reg;
    logic [RATE_W-1:0] rate_reg;
    logic              lro_reg;
    logic [7:0]        blk_rows [MAX_SF];
    int                blk_fill;
    logic              blk_hdr;
    sym_exp_t          pending_symbols [$];

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int clamp_sf();
        int s;
        s = sf_reg;
        if (s < MIN_SF)
            s = MIN_SF;
        if (s > MAX_SF)
            s = MAX_SF;
        return s;
    endfunction

    function automatic int clamp_rate();
        int r;
        r = rate_reg;
        if (r < 1)
            r = 1;
        if (r > 4)
            r = 4;
        return r;
    endfunction

    function automatic logic [7:0] codeword(input logic [3:0] nib, input int rate);
        logic d0, d1, d2, d3;
        logic [7:0] full;
        d0 = nib[0];
        d1 = nib[1];
        d2 = nib[2];
        d3 = nib[3];
        if (rate <= 1)
            return {3'b000, d0, d1, d2, d3, d0 ^ d1 ^ d2 ^ d3};
        full = {d0, d1, d2, d3, d0 ^ d1 ^ d2, d1 ^ d2 ^ d3, d0 ^ d1 ^ d3, d0 ^ d2 ^ d3};
        return full >> (4 - rate);
    endfunction

    function automatic int gray_to_bin(input int g);
        int v, s;
        v = g;
        s = g >> 1;
        while (s != 0)
        begin
            v ^= s;
            s >>= 1;
        end
        return v;
    endfunction

    // Store one codeword; when the block closes, queue its symbols
    task automatic encode_nibble(input logic [3:0] nib, input logic hdr, input logic flush);
        int sf, rate, nrows, len, col, r, v, mask, i, j;
        sym_exp_t e;
        sf = clamp_sf();
        if (blk_fill == 0)
            blk_hdr = hdr;
        rate  = blk_hdr ? 4 : clamp_rate();
        nrows = (blk_hdr || lro_reg) ? sf - 2 : sf;
        if (blk_fill < MAX_SF)
        begin
            blk_rows[blk_fill] = codeword(nib, rate);
            blk_fill++;
        end
        if (!flush && blk_fill < nrows)
            return;
        len  = 4 + rate;
        mask = (1 << sf) - 1;
        for (i = 0; i < len; i++)
        begin
            col = 0;
            // Diagonal read: bit j of column i, counted from the MSB, comes from row (i-j-1) mod rows
            for (j = 0; j < nrows; j++)
            begin
                r   = (i + 2 * nrows - j - 1) % nrows;
                col = (col << 1) | ((blk_rows[r] >> (len - 1 - i)) & 1);
            end
            v = gray_to_bin(col);
            v = (v << (sf - nrows)) & mask;
            v = (v + 1) & mask;
            e.symbol = SYM_W'(v);
            e.last   = (i == len - 1);
            e.hdr    = blk_hdr;
            pending_symbols = {pending_symbols, e};
        end
        for (i = 0; i < MAX_SF; i++)
            blk_rows[i] = '0;
        blk_fill = 0;
    endtask

    task automatic note_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic push_nibble(input logic [3:0] nib, input logic hdr, input logic flush);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 7)
        begin
            nib_if.valid <= 1'b0;
            @(negedge clk);
        end
        nib_if.valid           <= 1'b1;
        nib_if.nibble          <= nib;
        nib_if.in_header_block <= hdr;
        nib_if.flush_block     <= flush;
        do
            @(posedge clk);
        while (!nib_if.ready);
        encode_nibble(nib, hdr, flush);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        case (idx)
            REG_SF:   sf_reg   = val;
            REG_RATE: rate_reg = val[RATE_W-1:0];
            REG_LRO:  lro_reg  = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Hold off requests until every queued symbol is back, then let the emitter settle
    task automatic drain_and_settle();
        @(negedge clk);
        nib_if.valid <= 1'b0;
        while (pending_symbols.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_default_header();
        push_nibble(4'h0, 1'b1, 1'b0);
        push_nibble(4'hF, 1'b1, 1'b0);
        push_nibble(4'h1, 1'b1, 1'b0);
        push_nibble(4'h8, 1'b1, 1'b0);
        push_nibble(4'h6, 1'b1, 1'b0);
        drain_and_settle();
    endtask

    task automatic test_code_rates();
        int rates [4];
        rates = '{0, 2, 3, 7};
        write_reg(REG_SF, 4'd6);
        write_reg(REG_LRO, 4'd0);
        foreach (rates[k])
        begin
            write_reg(REG_RATE, CFG_DATA_W'(rates[k]));
            push_nibble(4'(4 * k + 3), 1'b0, 1'b1);
            drain_and_settle();
        end
    endtask

    task automatic test_sf_extremes();
        write_reg(REG_SF, 4'd15);
        write_reg(REG_RATE, 4'd4);
        write_reg(REG_LRO, 4'd1);
        push_nibble(4'hF, 1'b0, 1'b1);
        drain_and_settle();
        write_reg(REG_SF, 4'd0);
        write_reg(REG_LRO, 4'd0);
        push_nibble(4'h9, 1'b0, 1'b0);
        push_nibble(4'h6, 1'b0, 1'b1);
        drain_and_settle();
    endtask

    // The first request of a block decides its kind
    task automatic test_tag_change();
        write_reg(REG_SF, 4'd8);
        write_reg(REG_RATE, 4'd2);
        push_nibble(4'h3, 1'b0, 1'b0);
        push_nibble(4'hC, 1'b1, 1'b1);
        drain_and_settle();
        push_nibble(4'hA, 1'b1, 1'b0);
        push_nibble(4'h5, 1'b0, 1'b1);
        drain_and_settle();
    endtask

    // Shrink the block to six rows once six are filled: the next request closes it
    task automatic test_midblock_settings();
        int k;
        write_reg(REG_SF, 4'd12);
        write_reg(REG_RATE, 4'd2);
        write_reg(REG_LRO, 4'd0);
        for (k = 0; k < 6; k++)
            push_nibble(4'(k * 5 + 2), 1'b0, 1'b0);
        drain_and_settle();
        write_reg(REG_RATE, 4'd4);
        write_reg(REG_SF, 4'd6);
        push_nibble(4'hE, 1'b1, 1'b0);
        drain_and_settle();
    endtask

    task automatic test_random_traffic();
        int phase, done, blen, k;
        logic hdr_blk, tag, fl;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_and_settle();
            steady = (phase == 3);
            case (phase)
                0:
                begin
                    write_reg(REG_SF, 4'd12);
                    write_reg(REG_RATE, 4'd4);
                    write_reg(REG_LRO, 4'd0);
                end
                1:
                begin
                    write_reg(REG_SF, 4'd6);
                    write_reg(REG_RATE, 4'd1);
                    write_reg(REG_LRO, 4'd1);
                end
                default:
                begin
                    write_reg(REG_SF, 4'($urandom_range(0, 15)));
                    write_reg(REG_RATE, 4'($urandom_range(0, 7)));
                    write_reg(REG_LRO, 4'($urandom_range(0, 1)));
                end
            endcase
            done = 0;
            while (done < PHASE_ITEMS)
            begin
                hdr_blk = ($urandom_range(0, 3) == 0);
                blen    = $urandom_range(1, MAX_SF);
                for (k = 0; k < blen && done < PHASE_ITEMS; k++)
                begin
                    // Mostly consistent tags, with a stray one now and then
                    tag = ($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1)) : hdr_blk;
                    fl  = (k == blen - 1) ? 1'($urandom_range(0, 1))
                                          : ($urandom_range(0, 19) == 0);
                    push_nibble(4'($urandom_range(0, 15)), tag, fl);
                    done++;
                end
            end
        end
        steady = 1'b0;
    endtask

    always @(negedge clk)
        sym_if.ready <= steady || ($urandom_range(0, 99) >= 7);

    always @(posedge clk)
    begin
        sym_exp_t e;
        if (rst_n && sym_if.valid && sym_if.ready)
        begin
            if (pending_symbols.size() == 0)
                note_mismatch($sformatf("unexpected symbol %0d", sym_if.symbol));
            else
            begin
                e = pending_symbols.pop_front();
                if (sym_if.symbol !== e.symbol)
                    note_mismatch($sformatf("symbol %0d, want %0d", sym_if.symbol, e.symbol));
                if (sym_if.last_of_block !== e.last)
                    note_mismatch($sformatf("last_of_block %b, want %b",
                                            sym_if.last_of_block, e.last));
                if (sym_if.from_header_block !== e.hdr)
                    note_mismatch($sformatf("from_header_block %b, want %b",
                                            sym_if.from_header_block, e.hdr));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((nib_if.valid && nib_if.ready) || (sym_if.valid && sym_if.ready)
                || (cfg_if.valid && cfg_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int k;
        rst_n                  = 1'b0;
        steady                 = 1'b0;
        mismatches             = 0;
        quiet_cycles           = 0;
        nib_if.valid           = 1'b0;
        nib_if.nibble          = '0;
        nib_if.in_header_block = 1'b0;
        nib_if.flush_block     = 1'b0;
        sym_if.ready           = 1'b1;
        cfg_if.valid           = 1'b0;
        cfg_if.index           = '0;
        cfg_if.data            = '0;
        sf_reg                 = 4'd7;
        rate_reg               = 3'd1;
        lro_reg                = 1'b0;
        blk_fill               = 0;
        blk_hdr                = 1'b0;
        for (k = 0; k < MAX_SF; k++)
            blk_rows[k] = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_header();
        test_code_rates();
        test_sf_extremes();
        test_tag_change();
        test_midblock_settings();
        test_random_traffic();
        drain_and_settle();

        if (mismatches == 0 && pending_symbols.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// File: hamming_diag_interleave_encoder.f
+incdir+hdl
hdl/hdie_pkg.sv
hdl/hdie_intf.sv
hdl/hdie_front.sv
hdl/hdie_queue.sv
hdl/hdie_back.sv
hdl/hamming_diag_interleave_encoder.sv
tb/hamming_diag_interleave_encoder_tb.sv
